>>> src/three_wire_tuner_bus_master_defines.svh
// Assertion macros for the three-wire tuner bus master.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef THREE_WIRE_TUNER_BUS_MASTER_DEFINES_SVH
`define THREE_WIRE_TUNER_BUS_MASTER_DEFINES_SVH

// same-cycle implication
`define TWTBM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("three-wire bus master: same-cycle check failed");

// next-cycle implication
`define TWTBM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("three-wire bus master: next-cycle check failed");

`endif

>>> src/twtbm_pkg.sv
// Shared types and constants for the three-wire tuner bus master.
// No dependencies.
`default_nettype none

package twtbm_pkg;

    localparam int PHASE_W = 10;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 10'd10;

    localparam int CMD_W = 2;

    // code 3 is not a command and is treated as idle
    typedef enum logic [CMD_W-1:0] {
        CMD_IDLE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    // pin levels and flags after one tick
    typedef struct packed {
        logic ce;
        logic cl;
        logic di;
        logic busy;
        logic done;
    } t_pins;

    // sequencer status seen by the top level
    typedef struct packed {
        logic active;
        logic finishing;
    } t_seq_status;

endpackage

`default_nettype wire

>>> src/twtbm_tick_if.sv
// Tick channel: one beat per timing tick, carries command and pin sample.
// Depends on twtbm_pkg.
`default_nettype none

interface twtbm_tick_if #(
    parameter int ADDR_BITS = 2,
    parameter int DATA_BITS = 21
) ();
    logic                         valid;
    logic                         ready;
    logic [twtbm_pkg::CMD_W-1:0]  cmd;
    logic [ADDR_BITS-1:0]         addr;
    logic [DATA_BITS-1:0]         wdata;
    logic                         do_pin;

    modport source (output valid, cmd, addr, wdata, do_pin, input ready);
    modport sink   (input valid, cmd, addr, wdata, do_pin, output ready);
endinterface

`default_nettype wire

>>> src/twtbm_res_if.sv
// Result channel: one beat per tick with pin levels, flags and read data.
// No dependencies.
`default_nettype none

interface twtbm_res_if #(
    parameter int DATA_BITS = 21
) ();
    logic                 valid;
    logic                 ready;
    logic                 ce_pin;
    logic                 cl_pin;
    logic                 di_pin;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] rdata;

    modport source (output valid, ce_pin, cl_pin, di_pin, busy_res, done_res, rdata,
                    input ready);
    modport sink   (input valid, ce_pin, cl_pin, di_pin, busy_res, done_res, rdata,
                    output ready);
endinterface

`default_nettype wire

>>> src/twtbm_seq.sv
// Pin sequencer: transaction state, phase timer, shift registers, phase register.
// Depends on twtbm_pkg.
`default_nettype none

module twtbm_seq #(
    parameter int ADDR_BITS = 2,
    parameter int DATA_BITS = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [twtbm_pkg::PHASE_W-1:0] i_cfg_wdata,
    input  wire logic                          i_step,
    input  wire logic [twtbm_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [ADDR_BITS-1:0]          i_addr,
    input  wire logic [DATA_BITS-1:0]          i_wdata,
    input  wire logic                          i_do_pin,
    output twtbm_pkg::t_pins                   o_pins,
    output logic [DATA_BITS-1:0]               o_rdata,
    output twtbm_pkg::t_seq_status             o_status
);

    localparam int TOTAL_BITS = ADDR_BITS + DATA_BITS;
    localparam int PHASES     = 2 * TOTAL_BITS;
    localparam int BP_W       = $clog2(PHASES + 1);
    localparam int PW         = twtbm_pkg::PHASE_W;

    localparam logic [BP_W-1:0] PHASE_END  = BP_W'(PHASES);
    localparam logic [BP_W-2:0] ADDR_SLOTS = (BP_W-1)'(ADDR_BITS);

    logic [PW-1:0]         r_phase_ticks;
    logic                  r_active,    n_active;
    logic                  r_is_read,   n_is_read;
    logic [BP_W-1:0]       r_bit_phase, n_bit_phase;
    logic [PW-1:0]         r_tick,      n_tick;
    logic [TOTAL_BITS-1:0] r_out_shift, n_out_shift;
    logic [DATA_BITS-1:0]  r_in_shift,  n_in_shift;
    logic                  r_ce, n_ce;
    logic                  r_cl, n_cl;
    logic                  r_di, n_di;
    logic                  done;

    logic [PW-1:0] pt;
    logic [PW:0]   tick_inc;
    logic          last;
    logic          msb;
    logic          finishing;
    logic          start;
    logic          cmd_read;

    assign pt        = (r_phase_ticks == '0) ? PW'(1) : r_phase_ticks;
    assign tick_inc  = {1'b0, r_tick} + (PW+1)'(1);
    assign last      = tick_inc >= {1'b0, pt};
    assign msb       = r_out_shift[TOTAL_BITS-1];
    assign finishing = r_active && (r_bit_phase >= PHASE_END);
    assign cmd_read  = (i_cmd == twtbm_pkg::CMD_READ);
    assign start     = !r_active && (cmd_read || (i_cmd == twtbm_pkg::CMD_WRITE));

    always_comb begin
        n_active    = r_active;
        n_is_read   = r_is_read;
        n_bit_phase = r_bit_phase;
        n_tick      = r_tick;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_ce        = r_ce;
        n_cl        = r_cl;
        n_di        = r_di;
        done        = 1'b0;
        if (!r_active) begin
            if (start) begin
                n_active    = 1'b1;
                n_is_read   = cmd_read;
                n_bit_phase = '0;
                n_tick      = '0;
                n_out_shift = {i_addr, cmd_read ? {DATA_BITS{1'b0}} : i_wdata};
                if (cmd_read) begin
                    n_in_shift = '0;
                end
                n_ce = 1'b1;
                n_cl = 1'b1;
            end
        end else if (finishing) begin
            n_ce        = 1'b0;
            n_active    = 1'b0;
            done        = 1'b1;
            n_bit_phase = '0;
            n_tick      = '0;
        end else begin
            // even phase is clock low, odd is clock high
            if (!r_bit_phase[0]) begin
                n_cl = 1'b0;
                if (r_is_read) begin
                    if (r_bit_phase[BP_W-1:1] < ADDR_SLOTS) begin
                        if (r_tick == '0) begin
                            n_di = msb;
                        end
                        if (last) begin
                            n_out_shift = {r_out_shift[TOTAL_BITS-2:0], 1'b0};
                        end
                    end else if (last) begin
                        n_in_shift = {r_in_shift[DATA_BITS-2:0], i_do_pin};
                    end
                end else if (last) begin
                    n_di        = msb;
                    n_out_shift = {r_out_shift[TOTAL_BITS-2:0], 1'b0};
                end
            end else begin
                n_cl = 1'b1;
            end
            if (last) begin
                n_tick      = '0;
                n_bit_phase = r_bit_phase + BP_W'(1);
            end else begin
                n_tick = r_tick + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= twtbm_pkg::PHASE_RESET;
            r_active      <= 1'b0;
            r_is_read     <= 1'b0;
            r_bit_phase   <= '0;
            r_tick        <= '0;
            r_out_shift   <= '0;
            r_in_shift    <= '0;
            r_ce          <= 1'b0;
            r_cl          <= 1'b0;
            r_di          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (i_step) begin
                r_active    <= n_active;
                r_is_read   <= n_is_read;
                r_bit_phase <= n_bit_phase;
                r_tick      <= n_tick;
                r_out_shift <= n_out_shift;
                r_in_shift  <= n_in_shift;
                r_ce        <= n_ce;
                r_cl        <= n_cl;
                r_di        <= n_di;
            end
        end
    end

    assign o_pins   = '{ce: n_ce, cl: n_cl, di: n_di, busy: n_active, done: done};
    assign o_rdata  = n_in_shift;
    assign o_status = '{active: r_active, finishing: finishing};

endmodule

`default_nettype wire

>>> src/three_wire_tuner_bus_master.sv
// Three-wire tuner bus master, top level. One tick beat in, one result beat out.
// The result of a tick is on the output register the cycle after acceptance.
// Throughput: one tick per cycle unless o_res stalls; state updates per accepted beat.
// The tick channel stays ready while the held result is being taken.
// Reset (synchronous, active low): idle, pins low, phase length 10, no result held.
// Depends on twtbm_pkg, twtbm_tick_if, twtbm_res_if, twtbm_seq and the defines header.
`default_nettype none
`include "three_wire_tuner_bus_master_defines.svh"

module three_wire_tuner_bus_master #(
    parameter int ADDR_BITS = 2,
    parameter int DATA_BITS = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [twtbm_pkg::PHASE_W-1:0] i_cfg_wdata,
    twtbm_tick_if.sink                         i_tick,
    twtbm_res_if.source                        o_res
);

    twtbm_pkg::t_pins       w_pins;
    twtbm_pkg::t_seq_status w_status;
    logic [DATA_BITS-1:0]   w_rdata;
    logic                   w_step;
    logic                   w_run_step;
    logic                   w_end_step;

    twtbm_pkg::t_pins       r_out;
    logic [DATA_BITS-1:0]   r_rdata;
    logic                   r_out_valid;

    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign w_step       = i_tick.valid && i_tick.ready;
    assign w_run_step   = w_step && w_status.active && !w_status.finishing;
    assign w_end_step   = w_step && w_status.finishing;

    twtbm_seq #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_cmd       (i_tick.cmd),
        .i_addr      (i_tick.addr),
        .i_wdata     (i_tick.wdata),
        .i_do_pin    (i_tick.do_pin),
        .o_pins      (w_pins),
        .o_rdata     (w_rdata),
        .o_status    (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out   <= w_pins;
            r_rdata <= w_rdata;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.ce_pin   = r_out.ce;
    assign o_res.cl_pin   = r_out.cl;
    assign o_res.di_pin   = r_out.di;
    assign o_res.busy_res = r_out.busy;
    assign o_res.done_res = r_out.done;
    assign o_res.rdata    = r_rdata;

    // a running transaction ignores commands and stays busy until its last slot
    `TWTBM_ASSERT_NEXT(a_busy_holds, w_run_step, r_out_valid && r_out.busy && !r_out.done)
    // the tick after the last slot drops CE and flags done
    `TWTBM_ASSERT_NEXT(a_finish_done, w_end_step, r_out_valid && r_out.done && !r_out.ce && !r_out.busy)
    // CE is high exactly while a transaction runs
    `TWTBM_ASSERT_IMPL(a_ce_tracks_busy, r_out_valid, r_out.ce == r_out.busy)

endmodule

`default_nettype wire

>>> verif/twtbm_bus_checker.sv
`timescale 1ns / 100ps
// Checker for the three-wire tuner bus master: watches the tick and result channels,
// predicts pin levels, flags and read data for every tick and compares them beat by beat.
// Depends on twtbm_pkg and the twtbm_tick_if / twtbm_res_if channel interfaces.

module twtbm_bus_checker #(
    parameter int ADDR_BITS = 2,
    parameter int DATA_BITS = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [twtbm_pkg::PHASE_W-1:0] i_cfg_wdata,
    twtbm_tick_if                              tick,
    twtbm_res_if                               res,
    output int                                 o_errors,
    output int                                 o_outstanding
);

    localparam int FRAME_BITS  = ADDR_BITS + DATA_BITS;
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic                 ce;
        logic                 cl;
        logic                 di;
        logic                 busy;
        logic                 done;
        logic [DATA_BITS-1:0] rdata;
    } t_bus_view;

    t_bus_view pin_forecast[$];

    // shadow of the sequencer
    logic [twtbm_pkg::PHASE_W-1:0] phase_len;
    logic                          seq_active;
    logic                          seq_read;
    logic [5:0]                    slot_idx;
    logic [twtbm_pkg::PHASE_W-1:0] slot_ticks;
    logic [FRAME_BITS-1:0]         frame_sr;
    logic [DATA_BITS-1:0]          sample_sr;
    logic                          ce_lvl;
    logic                          cl_lvl;
    logic                          di_lvl;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_errors++;
            // keep the log short on a badly broken block
            if (o_errors <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic step_pins(input logic [twtbm_pkg::CMD_W-1:0] cmd,
                             input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] wdata, input logic dop,
                             output t_bus_view view);
        int   eff_len;
        int   bit_no;
        logic low_half;
        logic last_tick;
        logic top_bit;
        eff_len = (phase_len == '0) ? 1 : int'(phase_len);
        view.done = 1'b0;
        if (!seq_active) begin
            if (cmd == twtbm_pkg::CMD_READ || cmd == twtbm_pkg::CMD_WRITE) begin
                seq_active = 1'b1;
                seq_read   = (cmd == twtbm_pkg::CMD_READ);
                slot_idx   = '0;
                slot_ticks = '0;
                frame_sr   = seq_read ? {addr, {DATA_BITS{1'b0}}} : {addr, wdata};
                if (seq_read)
                    sample_sr = '0;
                ce_lvl = 1'b1;
                cl_lvl = 1'b1;
            end
        end else if (int'(slot_idx) >= 2 * FRAME_BITS) begin
            ce_lvl     = 1'b0;
            seq_active = 1'b0;
            view.done  = 1'b1;
            slot_idx   = '0;
            slot_ticks = '0;
        end else begin
            bit_no    = int'(slot_idx) >> 1;
            low_half  = !slot_idx[0];
            last_tick = (int'(slot_ticks) + 1 >= eff_len);
            top_bit   = frame_sr[FRAME_BITS-1];
            if (low_half) begin
                cl_lvl = 1'b0;
                if (seq_read) begin
                    // read: address bit goes out on the first low tick, data is
                    // sampled on the last one
                    if (bit_no < ADDR_BITS) begin
                        if (slot_ticks == '0)
                            di_lvl = top_bit;
                        if (last_tick)
                            frame_sr = frame_sr << 1;
                    end else if (last_tick) begin
                        sample_sr = {sample_sr[DATA_BITS-2:0], dop};
                    end
                end else if (last_tick) begin
                    di_lvl   = top_bit;
                    frame_sr = frame_sr << 1;
                end
            end else begin
                cl_lvl = 1'b1;
            end
            if (last_tick) begin
                slot_ticks = '0;
                slot_idx   = slot_idx + 6'd1;
            end else begin
                slot_ticks = slot_ticks + 1'b1;
            end
        end
        view.ce    = ce_lvl;
        view.cl    = cl_lvl;
        view.di    = di_lvl;
        view.busy  = seq_active;
        view.rdata = sample_sr;
    endtask

    always @(posedge i_clk) begin
        t_bus_view want;
        t_bus_view next_view;
        if (!i_rst_n) begin
            phase_len  = twtbm_pkg::PHASE_RESET;
            seq_active = 1'b0;
            seq_read   = 1'b0;
            slot_idx   = '0;
            slot_ticks = '0;
            frame_sr   = '0;
            sample_sr  = '0;
            ce_lvl     = 1'b0;
            cl_lvl     = 1'b0;
            di_lvl     = 1'b0;
            o_errors   = 0;
            pin_forecast.delete();
        end else begin
            // compare before predicting: a result beat always belongs to an older tick
            if (res.valid && res.ready) begin
                if (pin_forecast.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: result beat expected none, got ce=%0b cl=%0b di=%0b",
                                 $time, res.ce_pin, res.cl_pin, res.di_pin);
                end else begin
                    want = pin_forecast.pop_front();
                    check_field("ce_pin", 32'(want.ce), 32'(res.ce_pin));
                    check_field("cl_pin", 32'(want.cl), 32'(res.cl_pin));
                    check_field("di_pin", 32'(want.di), 32'(res.di_pin));
                    check_field("busy_res", 32'(want.busy), 32'(res.busy_res));
                    check_field("done_res", 32'(want.done), 32'(res.done_res));
                    check_field("rdata", 32'(want.rdata), 32'(res.rdata));
                end
            end
            if (tick.valid && tick.ready) begin
                step_pins(tick.cmd, tick.addr, tick.wdata, tick.do_pin, next_view);
                pin_forecast.push_back(next_view);
            end
            if (i_cfg_we)
                phase_len = i_cfg_wdata;
        end
        o_outstanding = pin_forecast.size();
    end

endmodule

>>> verif/tb_three_wire_tuner_bus_master.sv
`timescale 1ns / 100ps
// Testbench top for the three-wire tuner bus master: clock, reset, tick stimulus,
// result-side stalls and the verdict. Depends on twtbm_pkg, the channel interfaces,
// three_wire_tuner_bus_master and twtbm_bus_checker.

module tb_three_wire_tuner_bus_master;

    localparam int ADDR_BITS    = 2;
    localparam int DATA_BITS    = 21;
    localparam int FRAME_SLOTS  = 2 * (ADDR_BITS + DATA_BITS);
    localparam int RANDOM_TICKS = 550;

    // cmd code 3 is not a command; the block must treat it as an idle tick
    localparam logic [twtbm_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    localparam int DOP_RANDOM = 0;
    localparam int DOP_LOW    = 1;
    localparam int DOP_HIGH   = 2;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [twtbm_pkg::PHASE_W-1:0] cfg_wdata;
    int                            errors;
    int                            outstanding;
    int                            tick_total;
    logic                          sender_quiet;
    logic [twtbm_pkg::PHASE_W-1:0] cur_phase;

    twtbm_tick_if #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(DATA_BITS)) tick_bus ();
    twtbm_res_if  #(.DATA_BITS(DATA_BITS))                        res_bus ();

    three_wire_tuner_bus_master #(
        .ADDR_BITS(ADDR_BITS),
        .DATA_BITS(DATA_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_tick     (tick_bus),
        .o_res      (res_bus)
    );

    twtbm_bus_checker #(
        .ADDR_BITS(ADDR_BITS),
        .DATA_BITS(DATA_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .tick         (tick_bus),
        .res          (res_bus),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input logic quiet);
        int r;
        r = int'($urandom_range(99));
        if (quiet || r < 60)
            return 0;
        if (r < 88)
            return int'($urandom_range(3, 1));
        if (r < 98)
            return int'($urandom_range(10, 4));
        return int'($urandom_range(40, 12));
    endfunction

    // result side: random stalls with stretches of steady ready
    initial begin
        int stall;
        int calm;
        res_bus.ready = 1'b0;
        stall = 0;
        calm  = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                stall--;
            end else begin
                res_bus.ready <= 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(99) < 3)
                    calm = int'($urandom_range(300, 50));
                else
                    stall = pick_gap(1'b0);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_tick(input logic [twtbm_pkg::CMD_W-1:0] cmd,
                             input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] wdata, input logic dop);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0) begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_bus.valid  <= 1'b1;
        tick_bus.cmd    <= cmd;
        tick_bus.addr   <= addr;
        tick_bus.wdata  <= wdata;
        tick_bus.do_pin <= dop;
        @(posedge i_clk);
        while (!tick_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        tick_total++;
    endtask

    task automatic idle_ticks(input int count);
        repeat (count)
            send_tick($urandom_range(1) ? twtbm_pkg::CMD_IDLE : CMD_RESERVED,
                      ADDR_BITS'($urandom), DATA_BITS'($urandom), 1'($urandom_range(1)));
    endtask

    // one whole frame: start beat, every slot tick, then the completion tick
    task automatic run_transfer(input logic [twtbm_pkg::CMD_W-1:0] kind,
                                input logic [ADDR_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] wdata, input int dop_sel,
                                input logic noisy);
        int                            busy_ticks;
        logic                          dop;
        logic [twtbm_pkg::CMD_W-1:0]   cmd;
        busy_ticks = FRAME_SLOTS * ((cur_phase == '0) ? 1 : int'(cur_phase));
        send_tick(kind, addr, wdata, 1'($urandom_range(1)));
        for (int i = 0; i < busy_ticks; i++) begin
            dop = (dop_sel == DOP_LOW)  ? 1'b0 :
                  (dop_sel == DOP_HIGH) ? 1'b1 : 1'($urandom_range(1));
            cmd = noisy ? twtbm_pkg::CMD_W'($urandom_range(3)) : twtbm_pkg::CMD_IDLE;
            send_tick(cmd, ADDR_BITS'($urandom), DATA_BITS'($urandom), dop);
        end
        // a command on the completion tick must be dropped
        cmd = !noisy ? twtbm_pkg::CMD_IDLE :
              ($urandom_range(1) ? twtbm_pkg::CMD_READ : twtbm_pkg::CMD_WRITE);
        send_tick(cmd, ADDR_BITS'($urandom), DATA_BITS'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic set_phase(input logic [twtbm_pkg::PHASE_W-1:0] value);
        tick_bus.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        cur_phase = value;
    endtask

    initial begin
        int rand_start;
        int r;
        int phase_pick;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        tick_bus.valid  = 1'b0;
        tick_bus.cmd    = twtbm_pkg::CMD_IDLE;
        tick_bus.addr   = '0;
        tick_bus.wdata  = '0;
        tick_bus.do_pin = 1'b0;
        sender_quiet    = 1'b0;
        cur_phase       = twtbm_pkg::PHASE_RESET;
        tick_total      = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset phase length first
        send_tick(twtbm_pkg::CMD_IDLE, '0, '0, 1'b0);
        send_tick(CMD_RESERVED, '1, '1, 1'b1);
        run_transfer(twtbm_pkg::CMD_WRITE, 2'd3, '1, DOP_RANDOM, 1'b1);
        run_transfer(twtbm_pkg::CMD_READ, 2'd0, '0, DOP_HIGH, 1'b0);
        idle_ticks(2);
        // zero phase length runs as one tick per phase
        set_phase('0);
        run_transfer(twtbm_pkg::CMD_WRITE, 2'd0, '0, DOP_LOW, 1'b0);
        run_transfer(twtbm_pkg::CMD_READ, 2'd3, '1, DOP_LOW, 1'b1);
        run_transfer(twtbm_pkg::CMD_READ, 2'd2, '0, DOP_RANDOM, 1'b0);
        run_transfer(twtbm_pkg::CMD_WRITE, 2'd1, 21'h155555, DOP_RANDOM, 1'b1);
        idle_ticks(1);
        // longest phase length: idle ticks only, a full frame would be far too long
        set_phase('1);
        idle_ticks(2);
        set_phase(10'd1);
        run_transfer(twtbm_pkg::CMD_WRITE, 2'd2, 21'h0AAAAA, DOP_RANDOM, 1'b0);

        // random: mostly short phases, well-formed frames with random content
        rand_start = tick_total;
        while (tick_total - rand_start < RANDOM_TICKS) begin
            r = int'($urandom_range(99));
            phase_pick = (r < 45) ? 1 :
                         (r < 70) ? 2 :
                         (r < 82) ? int'($urandom_range(6, 3)) :
                         (r < 90) ? 0 : int'($urandom_range(12, 7));
            set_phase(twtbm_pkg::PHASE_W'(phase_pick));
            repeat ($urandom_range(5, 2)) begin
                sender_quiet = ($urandom_range(99) < 20);
                if ($urandom_range(99) < 85)
                    run_transfer($urandom_range(1) ? twtbm_pkg::CMD_READ
                                                   : twtbm_pkg::CMD_WRITE,
                                 ADDR_BITS'($urandom), DATA_BITS'($urandom), DOP_RANDOM,
                                 $urandom_range(99) < 30);
                else
                    idle_ticks(int'($urandom_range(20, 1)));
                idle_ticks(int'($urandom_range(3)));
            end
        end
        sender_quiet = 1'b0;
        tick_bus.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/twtbm_pkg.sv
src/twtbm_tick_if.sv
src/twtbm_res_if.sv
src/twtbm_seq.sv
src/three_wire_tuner_bus_master.sv
verif/twtbm_bus_checker.sv
verif/tb_three_wire_tuner_bus_master.sv
